// ----- hdl/stwf_pkg.sv -----
// Shared types and constants for the spin target window filter.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package stwf_pkg;

  localparam int DATA_W = 16;

  typedef logic signed [DATA_W-1:0] coord_t;

  // One history entry: filtered x, raw y and raw z.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUSH = 3'b100
  } state_t;

endpackage

// ----- hdl/stwf_in_if.sv -----
// Input channel of the spin target window filter: valid/ready plus one position word.
// Depends on stwf_pkg.
interface stwf_in_if;
  logic            valid;
  logic            ready;
  logic            spin_mode;
  stwf_pkg::coord_t pos_x;
  stwf_pkg::coord_t pos_y;
  stwf_pkg::coord_t pos_z;

  modport source (output valid, spin_mode, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, spin_mode, pos_x, pos_y, pos_z, output ready);
endinterface

// ----- hdl/stwf_out_if.sv -----
// Output channel of the spin target window filter: valid/ready plus one filtered word.
// Depends on stwf_pkg.
interface stwf_out_if;
  logic            valid;
  logic            ready;
  stwf_pkg::coord_t out_x;
  stwf_pkg::coord_t out_y;
  stwf_pkg::coord_t out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- hdl/stwf_cell.sv -----
// One history cell of the filter's ring: holds one entry and hands it to the next cell.
// Depends on stwf_pkg.
module stwf_cell (
  input  logic             clk,
  input  logic             en,
  input  stwf_pkg::entry_t d,
  output stwf_pkg::entry_t q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

// ----- hdl/stwf_div.sv -----
// Signed division by a constant, truncating toward zero, by reciprocal multiplication.
// Depends on stwf_pkg.
module stwf_div #(
  parameter int DW      = 22,
  parameter int DIVISOR = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [DW-1:0]  dividend,
  output logic                  busy,
  output stwf_pkg::coord_t      quot
);

  // floor(mag * RECIP / 2^SHIFT) equals floor(mag / DIVISOR) for every mag below 2^DW.
  localparam int L     = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int SHIFT = DW + L;
  localparam int MW    = DW + 2;
  localparam int PW    = DW + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SHIFT) / 64'(DIVISOR)) + 64'd1);

  logic [DW-1:0] mag;
  logic          neg;
  logic [PW-1:0] prod;
  logic [DW-1:0] qmag;
  logic [DW-1:0] qs;

  assign qmag = DW'(prod >> SHIFT);
  assign qs   = neg ? (~qmag + DW'(1)) : qmag;
  assign quot = qs[stwf_pkg::DATA_W-1:0];

  // Magnitude lands the cycle after start, the product the cycle after that.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      mag <= dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
    end
    if (busy) begin
      prod <= PW'(mag) * PW'(RECIP);
    end
  end

endmodule

// ----- hdl/spin_target_window_filter.sv -----
// Top level of the spin target window filter: history ring of cells, min/max scan, mean dividers.
// Depends on stwf_pkg, stwf_in_if, stwf_out_if, stwf_cell and stwf_div.

// One position word is taken at a time. Its history lives in a ring of WINDOW cells; for
// every word the ring rotates once past a single min/max comparator at the oldest cell,
// while two reciprocal-multiply dividers, hidden under the rotation, form the y and z
// window means. A word passes from acceptance through the scan and push states into the
// output register, and the next word is taken only once the filter is back in idle.
// The result sits in an output register, so a slow sink stalls the block only when a
// second result is ready to load.
// Means are truncated toward zero; in spin mode with history, out_x is the centre of the
// min/max window shifted to contain the new x, rounded toward minus infinity.
module spin_target_window_filter #(
  parameter int WINDOW = 20
) (
  input  logic            clk,
  input  logic            rst,
  stwf_in_if.sink         in_ch,
  stwf_out_if.source      out_ch
);

  localparam int DW     = stwf_pkg::DATA_W;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int SUM_W  = DW + $clog2(WINDOW);
  localparam int TOT_W  = SUM_W + 1;
  localparam int EXT_W  = DW + 2;

  stwf_pkg::state_t state;
  logic             scan_done;
  logic [IDX_W-1:0] k;
  logic [FILL_W-1:0] fill;
  logic signed [SUM_W-1:0] y_sum;
  logic signed [SUM_W-1:0] z_sum;

  logic             spin_r;
  stwf_pkg::coord_t x_r;
  stwf_pkg::coord_t y_r;
  stwf_pkg::coord_t z_r;
  stwf_pkg::coord_t lo;
  stwf_pkg::coord_t hi;
  logic             have;

  logic             out_valid;
  stwf_pkg::coord_t ox_r;
  stwf_pkg::coord_t oy_r;
  stwf_pkg::coord_t oz_r;

  stwf_pkg::entry_t cell_d [WINDOW];
  stwf_pkg::entry_t cell_q [WINDOW];
  stwf_pkg::entry_t oldest;
  stwf_pkg::entry_t new_entry;
  logic             shift_en;

  logic             in_fire;
  logic             out_free;
  logic             push_fire;
  logic             full;
  logic             mean_ok;
  logic             take;
  logic signed [TOT_W-1:0] y_tot;
  logic signed [TOT_W-1:0] z_tot;
  logic             y_busy;
  logic             z_busy;
  stwf_pkg::coord_t y_mean;
  stwf_pkg::coord_t z_mean;
  stwf_pkg::coord_t ox;
  stwf_pkg::coord_t oy;
  stwf_pkg::coord_t oz;

  assign in_ch.ready = (state == stwf_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign push_fire   = (state == stwf_pkg::S_PUSH) && out_free;
  assign full        = (fill == FILL_W'(WINDOW));
  assign mean_ok     = (fill >= FILL_W'(WINDOW - 1));
  assign oldest      = cell_q[WINDOW-1];

  // History ring: rotate during the scan, push the new entry at cell 0.
  assign shift_en = ((state == stwf_pkg::S_SCAN) && !scan_done) || push_fire;
  assign cell_d[0] = push_fire ? new_entry : oldest;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_d[i] = cell_q[i-1];
    end
    stwf_cell u_cell (
      .clk (clk),
      .en  (shift_en),
      .d   (cell_d[i]),
      .q   (cell_q[i])
    );
  end

  // Window totals: stored sum plus the new sample, less the oldest when full.
  assign y_tot = TOT_W'(y_sum) + TOT_W'(in_ch.pos_y)
               - (full ? TOT_W'(oldest.y) : TOT_W'(0));
  assign z_tot = TOT_W'(z_sum) + TOT_W'(in_ch.pos_z)
               - (full ? TOT_W'(oldest.z) : TOT_W'(0));

  stwf_div #(.DW(TOT_W), .DIVISOR(WINDOW)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .dividend (y_tot),
    .busy     (y_busy),
    .quot     (y_mean)
  );

  stwf_div #(.DW(TOT_W), .DIVISOR(WINDOW)) u_div_z (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .dividend (z_tot),
    .busy     (z_busy),
    .quot     (z_mean)
  );

  // Entry leaving the oldest cell at step k sits at depth WINDOW-1-k; valid if below fill.
  assign take = ((FILL_W+1)'(k) + (FILL_W+1)'(fill)) >= (FILL_W+1)'(WINDOW);

  always_comb begin
    logic signed [EXT_W-1:0] xe;
    logic signed [EXT_W-1:0] loe;
    logic signed [EXT_W-1:0] hie;
    logic signed [EXT_W-1:0] lo2;
    logic signed [EXT_W-1:0] hi2;
    logic signed [EXT_W-1:0] s;
    xe  = EXT_W'(x_r);
    loe = EXT_W'(lo);
    hie = EXT_W'(hi);
    lo2 = loe;
    hi2 = hie;
    if (xe > hie) begin
      lo2 = loe + (xe - hie);
      hi2 = xe;
    end else if (xe < loe) begin
      lo2 = xe;
      hi2 = hie + (xe - loe);
    end
    s = (lo2 + hi2) >>> 1;
    if (spin_r && have) begin
      ox = s[DW-1:0];
    end else begin
      ox = x_r;
    end
  end

  assign oy = (spin_r && mean_ok) ? y_mean : y_r;
  assign oz = (spin_r && mean_ok) ? z_mean : z_r;

  assign new_entry.x = ox;
  assign new_entry.y = y_r;
  assign new_entry.z = z_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stwf_pkg::S_IDLE;
      scan_done <= 1'b0;
      k         <= '0;
      have      <= 1'b0;
      fill      <= '0;
      y_sum     <= '0;
      z_sum     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push_fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        stwf_pkg::S_IDLE: begin
          if (in_fire) begin
            state     <= stwf_pkg::S_SCAN;
            scan_done <= 1'b0;
            k         <= '0;
            have      <= 1'b0;
          end
        end
        stwf_pkg::S_SCAN: begin
          if (!scan_done) begin
            if (take) begin
              have <= 1'b1;
            end
            if (k == IDX_W'(WINDOW - 1)) begin
              scan_done <= 1'b1;
            end else begin
              k <= k + IDX_W'(1);
            end
          end else if (!y_busy && !z_busy) begin
            state <= stwf_pkg::S_PUSH;
          end
        end
        stwf_pkg::S_PUSH: begin
          if (out_free) begin
            state     <= stwf_pkg::S_IDLE;
            y_sum     <= y_sum + SUM_W'(y_r) - (full ? SUM_W'(oldest.y) : SUM_W'(0));
            z_sum     <= z_sum + SUM_W'(z_r) - (full ? SUM_W'(oldest.z) : SUM_W'(0));
            if (!full) begin
              fill <= fill + FILL_W'(1);
            end
          end
        end
        default: begin
          state <= stwf_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: latched word, running min/max, result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      spin_r <= in_ch.spin_mode;
      x_r    <= in_ch.pos_x;
      y_r    <= in_ch.pos_y;
      z_r    <= in_ch.pos_z;
    end
    if ((state == stwf_pkg::S_SCAN) && !scan_done && take) begin
      if (!have) begin
        lo <= oldest.x;
        hi <= oldest.x;
      end else begin
        if (oldest.x < lo) begin
          lo <= oldest.x;
        end
        if (oldest.x > hi) begin
          hi <= oldest.x;
        end
      end
    end
    if (push_fire) begin
      ox_r <= ox;
      oy_r <= oy;
      oz_r <= oz;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.out_x = ox_r;
  assign out_ch.out_y = oy_r;
  assign out_ch.out_z = oz_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW))
    else $error("history fill count beyond window");

  a_push_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == stwf_pkg::S_PUSH) |-> (scan_done && !y_busy && !z_busy))
    else $error("push entered before scan and dividers finished");

  a_result_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == stwf_pkg::S_PUSH))
    else $error("result raised outside push");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    push_fire && !full |=> fill == $past(fill) + FILL_W'(1))
    else $error("fill count did not advance on push");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking bench for spin_target_window_filter: a directed table, then random position words.
// Depends on stwf_pkg, stwf_in_if, stwf_out_if and the filter itself under hdl/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = 20;
  localparam int RANDOM_WORDS = 2000;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic             spin;
    stwf_pkg::coord_t x;
    stwf_pkg::coord_t y;
    stwf_pkg::coord_t z;
    logic             known;
    stwf_pkg::entry_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stwf_in_if  in_ch ();
  stwf_out_if out_ch ();

  spin_target_window_filter #(
    .WINDOW (WIN)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // history of the filter as seen from outside
  stwf_pkg::coord_t   hist_x [WIN];
  stwf_pkg::coord_t   hist_y [WIN];
  stwf_pkg::coord_t   hist_z [WIN];
  logic [4:0]         fill_cnt = '0;
  logic [4:0]         wr_ptr   = '0;
  logic signed [20:0] y_sum    = '0;
  logic signed [20:0] z_sum    = '0;

  stwf_pkg::entry_t pending_filtered [$];
  stim_row_t        directed_rows [$];
  int               track_x = 0;
  int               track_y = 0;
  int               track_z = 0;

  // mean of the current sample and the WIN-1 newest stored ones, truncated toward zero
  function automatic stwf_pkg::coord_t window_mean(logic signed [20:0] sum,
                                                   stwf_pkg::coord_t oldest,
                                                   stwf_pkg::coord_t cur);
    logic signed [21:0] total;
    logic signed [21:0] quo;
    total = 22'(sum) + 22'(cur);
    if (fill_cnt == 5'(WIN)) total = total - 22'(oldest);
    quo = total / 22'(WIN);
    return quo[15:0];
  endfunction

  function automatic stwf_pkg::entry_t filter_position(logic spin, stwf_pkg::coord_t px,
                                                       stwf_pkg::coord_t py,
                                                       stwf_pkg::coord_t pz);
    stwf_pkg::entry_t   res;
    stwf_pkg::coord_t   lo;
    stwf_pkg::coord_t   hi;
    logic signed [17:0] shift;
    logic signed [17:0] span;
    logic [4:0]         first;
    logic [4:0]         idx;
    res.x = px;
    res.y = py;
    res.z = pz;
    if (spin) begin
      if (fill_cnt != 5'd0) begin
        first = 5'((int'(wr_ptr) + WIN - int'(fill_cnt)) % WIN);
        idx = first;
        lo = hist_x[idx];
        hi = hist_x[idx];
        for (int i = 1; i < int'(fill_cnt); i++) begin
          idx = (idx == 5'(WIN - 1)) ? 5'd0 : idx + 5'd1;
          if (hist_x[idx] < lo) lo = hist_x[idx];
          if (hist_x[idx] > hi) hi = hist_x[idx];
        end
        // slide the min/max window just far enough to cover the new x
        shift = '0;
        if (px > hi) shift = 18'(px) - 18'(hi);
        else if (px < lo) shift = 18'(px) - 18'(lo);
        span = (18'(lo) + shift) + (18'(hi) + shift);
        span = span >>> 1;
        res.x = span[15:0];
      end
      if (fill_cnt >= 5'(WIN - 1)) begin
        res.y = window_mean(y_sum, hist_y[wr_ptr], py);
        res.z = window_mean(z_sum, hist_z[wr_ptr], pz);
      end
    end
    // drop the oldest entry once full, then record filtered x and raw y, z
    if (fill_cnt == 5'(WIN)) begin
      y_sum = y_sum - 21'(hist_y[wr_ptr]);
      z_sum = z_sum - 21'(hist_z[wr_ptr]);
    end else begin
      fill_cnt = fill_cnt + 5'd1;
    end
    hist_x[wr_ptr] = res.x;
    hist_y[wr_ptr] = py;
    hist_z[wr_ptr] = pz;
    y_sum = y_sum + 21'(py);
    z_sum = z_sum + 21'(pz);
    wr_ptr = (wr_ptr == 5'(WIN - 1)) ? 5'd0 : wr_ptr + 5'd1;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_filtered(stwf_pkg::coord_t gx, stwf_pkg::coord_t gy,
                                stwf_pkg::coord_t gz);
    stwf_pkg::entry_t want;
    if (pending_filtered.size() == 0) begin
      report_mismatch($sformatf("unexpected word x=%0d y=%0d z=%0d", gx, gy, gz));
    end else begin
      want = pending_filtered[0];
      pending_filtered.delete(0);
      if (gx !== want.x) report_mismatch($sformatf("out_x %0d, expected %0d", gx, want.x));
      if (gy !== want.y) report_mismatch($sformatf("out_y %0d, expected %0d", gy, want.y));
      if (gz !== want.z) report_mismatch($sformatf("out_z %0d, expected %0d", gz, want.z));
    end
  endtask

  function automatic void add_row(logic spin, int x, int y, int z,
                                  logic known, int ex, int ey, int ez);
    stim_row_t r;
    r.spin   = spin;
    r.x      = x[15:0];
    r.y      = y[15:0];
    r.z      = z[15:0];
    r.known  = known;
    r.want.x = ex[15:0];
    r.want.y = ey[15:0];
    r.want.z = ez[15:0];
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic int drift(int center);
    int v;
    if ($urandom_range(99) < 2) v = int'($urandom_range(65535)) - 32768;
    else v = center + int'($urandom_range(40)) - 20;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  // mostly near the tracked center, sometimes anywhere, now and then an extreme
  function automatic stwf_pkg::coord_t pick_coord(int center);
    int          v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) v = $urandom_range(1) ? 32767 : -32768;
    else if (pick < 16) v = int'($urandom_range(65535)) - 32768;
    else v = center + int'($urandom_range(400)) - 200;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_word(logic spin, stwf_pkg::coord_t px, stwf_pkg::coord_t py,
                           stwf_pkg::coord_t pz, logic known, stwf_pkg::entry_t want);
    stwf_pkg::entry_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.spin_mode <= spin;
    in_ch.pos_x     <= px;
    in_ch.pos_y     <= py;
    in_ch.pos_z     <= pz;
    do @(posedge clk); while (!in_ch.ready);
    predicted = filter_position(spin, px, py, pz);
    pending_filtered.insert(pending_filtered.size(), known ? want : predicted);
  endtask

  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_ch.valid && out_ch.ready) check_filtered(out_ch.out_x, out_ch.out_y, out_ch.out_z);
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[spin_target_window_filter] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic spin;
    in_ch.valid     <= 1'b0;
    in_ch.spin_mode <= 1'b0;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.pos_z     <= '0;

    // empty history, single entry, shift down, inside window, idle pass-through
    add_row(1'b1,    100,  32767, -32768, 1'b1,    100,  32767, -32768);
    add_row(1'b1,    300, -32768,  32767, 1'b1,    300, -32768,  32767);
    add_row(1'b1,     50,      5,     -5, 1'b1,    150,      5,     -5);
    add_row(1'b1,    200,      0,      0, 1'b1,    200,      0,      0);
    add_row(1'b0, -32768, -32768,  32767, 1'b1, -32768, -32768,  32767);
    add_row(1'b1,  32767,      1,     -1, 1'b0, 0, 0, 0);
    add_row(1'b1, -32768,     -1,      1, 1'b0, 0, 0, 0);
    add_row(1'b1,     -3,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1,      7,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1,     -8, -32768,  32767, 1'b0, 0, 0, 0);
    add_row(1'b0,  12345, -32768,  32767, 1'b0, 0, 0, 0);
    add_row(1'b1, -12345,      3,     -3, 1'b0, 0, 0, 0);
    add_row(1'b1,      0,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1,      1,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1,     -1,     -7,      7, 1'b0, 0, 0, 0);
    add_row(1'b1,  20000,     -7,      7, 1'b0, 0, 0, 0);
    add_row(1'b1, -20000,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1,      5, -32768,  32767, 1'b0, 0, 0, 0);
    add_row(1'b1,     -5,     11,    -11, 1'b0, 0, 0, 0);
    // first full window of y and z, then evictions
    add_row(1'b1,      9,    -13,     13, 1'b0, 0, 0, 0);
    add_row(1'b1,     -9,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1,  32767,  32767, -32768, 1'b0, 0, 0, 0);
    add_row(1'b1, -32768, -32768,  32767, 1'b0, 0, 0, 0);
    add_row(1'b1,      0,     -1,      1, 1'b0, 0, 0, 0);
    add_row(1'b0,      0,      0,      0, 1'b0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].spin, directed_rows[i].x, directed_rows[i].y,
                directed_rows[i].z, directed_rows[i].known, directed_rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
        track_x = drift(track_x);
        track_y = drift(track_y);
        track_z = drift(track_z);
        spin = ($urandom_range(99) >= 12);
        send_word(spin, pick_coord(track_x), pick_coord(track_y), pick_coord(track_z),
                  1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    while (pending_filtered.size() != 0) @(posedge clk);
    // hold a while longer to catch stray words
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[spin_target_window_filter] OK");
    end else begin
      $display("[spin_target_window_filter] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/stwf_pkg.sv
hdl/stwf_in_if.sv
hdl/stwf_out_if.sv
hdl/stwf_cell.sv
hdl/stwf_div.sv
hdl/spin_target_window_filter.sv
sim/tb.sv
